// ===== rtl/core/uod_pkg.sv =====
package uod_pkg;

    // trigger pulse shape, in ticks
    localparam int TRIG_LOW_TICKS  = 2;
    localparam int TRIG_HIGH_TICKS = 10;

    // field widths
    localparam int TIMEOUT_W = 16;
    localparam int NEAR_W    = 16;
    localparam int HOLD_W    = 24;
    localparam int GAP_W     = 20;
    localparam int ECHO_W    = 16;
    localparam int DIST_W    = 14;
    localparam int PHASE_W   = 20;

    // apb port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // distance = floor(echo * 343 / 2000) as floor(echo * DIST_MUL >> DIST_SHIFT),
    // exact for every 16-bit echo time
    localparam int DIST_SHIFT = 28;
    localparam int DIST_MUL_W = 26;
    localparam logic [DIST_MUL_W-1:0] DIST_MUL = 26'd46036681;
    localparam int PROD_W = ECHO_W + DIST_MUL_W;

    // reset values of the settings
    localparam logic [TIMEOUT_W-1:0] RST_ECHO_TIMEOUT = 16'd10000;
    localparam logic [NEAR_W-1:0]    RST_NEAR_LIMIT   = 16'd1749;
    localparam logic [HOLD_W-1:0]    RST_HOLD_TIME    = 24'd750000;
    localparam logic [GAP_W-1:0]     RST_GAP          = 20'd50000;

    typedef enum logic [1:0] {
        REG_ECHO_TIMEOUT = 2'd0,
        REG_NEAR_LIMIT   = 2'd1,
        REG_HOLD_TIME    = 2'd2,
        REG_GAP          = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] echo_timeout_us;
        logic [NEAR_W-1:0]    near_limit_us;
        logic [HOLD_W-1:0]    hold_time_us;
        logic [GAP_W-1:0]     gap_us;
    } t_cfg;

    typedef struct packed {
        logic              trig_level;
        logic              measure_done;
        logic              echo_valid;
        logic [ECHO_W-1:0] echo_us;
        logic              blocked;
        logic              block_event;
        logic              unblock_event;
    } t_result;

endpackage

// ===== rtl/core/uod_regs.sv =====
module uod_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [uod_pkg::APB_AW-1:0]  i_paddr,
    input  logic [uod_pkg::APB_DW-1:0]  i_pwdata,
    output logic [uod_pkg::APB_DW-1:0]  o_prdata,
    output uod_pkg::t_cfg               o_cfg
);
    import uod_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx = t_reg_idx'(i_paddr[APB_AW-1:2]);
    assign w_wr  = i_psel & i_penable & i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.echo_timeout_us <= RST_ECHO_TIMEOUT;
            r_cfg.near_limit_us   <= RST_NEAR_LIMIT;
            r_cfg.hold_time_us    <= RST_HOLD_TIME;
            r_cfg.gap_us          <= RST_GAP;
        end else if (w_wr) begin
            case (w_idx)
                REG_ECHO_TIMEOUT: r_cfg.echo_timeout_us <= i_pwdata[TIMEOUT_W-1:0];
                REG_NEAR_LIMIT:   r_cfg.near_limit_us   <= i_pwdata[NEAR_W-1:0];
                REG_HOLD_TIME:    r_cfg.hold_time_us    <= i_pwdata[HOLD_W-1:0];
                REG_GAP:          r_cfg.gap_us          <= i_pwdata[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ECHO_TIMEOUT: o_prdata = APB_DW'(r_cfg.echo_timeout_us);
            REG_NEAR_LIMIT:   o_prdata = APB_DW'(r_cfg.near_limit_us);
            REG_HOLD_TIME:    o_prdata = APB_DW'(r_cfg.hold_time_us);
            REG_GAP:          o_prdata = APB_DW'(r_cfg.gap_us);
            default:          o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/uod_dist.sv =====
module uod_dist (
    input  logic [uod_pkg::ECHO_W-1:0] i_echo_us,
    output logic [uod_pkg::DIST_W-1:0] o_distance_mm
);
    import uod_pkg::*;

    logic [PROD_W-1:0] w_prod;

    // reciprocal multiply, the shift drops the fraction
    assign w_prod        = PROD_W'(i_echo_us) * PROD_W'(DIST_MUL);
    assign o_distance_mm = w_prod[DIST_SHIFT +: DIST_W];

endmodule

// ===== rtl/core/uod_core.sv =====
module uod_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_echo_level,
    input  logic             i_run,
    input  uod_pkg::t_cfg    i_cfg,
    output uod_pkg::t_result o_res
);
    import uod_pkg::*;

    typedef enum logic [2:0] {
        PH_TLOW  = 3'd0,
        PH_THIGH = 3'd1,
        PH_RISE  = 3'd2,
        PH_HIGH  = 3'd3,
        PH_GAP   = 3'd4
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [PHASE_W-1:0] r_phase_ticks, n_phase_ticks;
    logic [ECHO_W-1:0]  r_echo_ticks, n_echo_ticks;
    logic               r_hold_active, n_hold_active;
    logic [HOLD_W-1:0]  r_hold_ticks, n_hold_ticks;
    logic [ECHO_W-1:0]  r_first_echo, n_first_echo;
    logic               r_block, n_block;
    logic [PHASE_W:0]   w_pt_inc;
    t_result            w_res;

    assign w_pt_inc = {1'b0, r_phase_ticks} + (PHASE_W+1)'(1);

    always_comb begin
        n_phase       = r_phase;
        n_phase_ticks = r_phase_ticks;
        n_echo_ticks  = r_echo_ticks;
        n_hold_active = r_hold_active;
        n_hold_ticks  = r_hold_ticks;
        n_first_echo  = r_first_echo;
        n_block       = r_block;
        w_res         = '0;

        if (!i_run) begin
            n_phase       = PH_TLOW;
            n_phase_ticks = '0;
            n_echo_ticks  = '0;
            n_hold_active = 1'b0;
            n_hold_ticks  = '0;
            n_first_echo  = '0;
            if (r_block) begin
                n_block             = 1'b0;
                w_res.unblock_event = 1'b1;
            end
        end else begin
            // hold timer saturates at all ones
            if (r_hold_active && (r_hold_ticks != '1)) begin
                n_hold_ticks = r_hold_ticks + HOLD_W'(1);
            end

            case (r_phase)
                PH_TLOW: begin
                    if (w_pt_inc >= (PHASE_W+1)'(TRIG_LOW_TICKS)) begin
                        n_phase       = PH_THIGH;
                        n_phase_ticks = '0;
                    end else begin
                        n_phase_ticks = w_pt_inc[PHASE_W-1:0];
                    end
                end
                PH_THIGH: begin
                    w_res.trig_level = 1'b1;
                    if (w_pt_inc >= (PHASE_W+1)'(TRIG_HIGH_TICKS)) begin
                        n_phase       = PH_RISE;
                        n_phase_ticks = '0;
                    end else begin
                        n_phase_ticks = w_pt_inc[PHASE_W-1:0];
                    end
                end
                PH_RISE: begin
                    if (i_echo_level) begin
                        n_phase       = PH_HIGH;
                        n_phase_ticks = '0;
                        n_echo_ticks  = ECHO_W'(1);
                    end else if (r_phase_ticks >= PHASE_W'(i_cfg.echo_timeout_us)) begin
                        w_res.measure_done = 1'b1;
                    end else begin
                        n_phase_ticks = w_pt_inc[PHASE_W-1:0];
                    end
                end
                PH_HIGH: begin
                    if (i_echo_level) begin
                        if (r_echo_ticks >= i_cfg.echo_timeout_us) begin
                            w_res.measure_done = 1'b1;
                        end else if (r_echo_ticks != '1) begin
                            n_echo_ticks = r_echo_ticks + ECHO_W'(1);
                        end
                    end else begin
                        w_res.measure_done = 1'b1;
                        w_res.echo_valid   = 1'b1;
                        w_res.echo_us      = r_echo_ticks;
                    end
                end
                PH_GAP: begin
                    if (w_pt_inc >= {1'b0, i_cfg.gap_us}) begin
                        n_phase       = PH_TLOW;
                        n_phase_ticks = '0;
                    end else begin
                        n_phase_ticks = w_pt_inc[PHASE_W-1:0];
                    end
                end
                default: begin
                    n_phase       = PH_TLOW;
                    n_phase_ticks = '0;
                end
            endcase

            if (w_res.measure_done) begin
                n_phase       = PH_GAP;
                n_phase_ticks = '0;
                n_echo_ticks  = '0;
                if (w_res.echo_valid && (w_res.echo_us <= i_cfg.near_limit_us)) begin
                    if (!r_hold_active) begin
                        n_hold_active = 1'b1;
                        n_hold_ticks  = '0;
                        n_first_echo  = w_res.echo_us;
                    end else if (n_hold_ticks >= i_cfg.hold_time_us) begin
                        if ((w_res.echo_us <= r_first_echo) && !r_block) begin
                            n_block           = 1'b1;
                            w_res.block_event = 1'b1;
                        end
                        n_hold_active = 1'b0;
                        n_hold_ticks  = '0;
                    end
                end else begin
                    n_hold_active = 1'b0;
                    n_hold_ticks  = '0;
                    n_first_echo  = '0;
                    if (r_block) begin
                        n_block             = 1'b0;
                        w_res.unblock_event = 1'b1;
                    end
                end
            end
        end

        w_res.blocked = n_block;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_TLOW;
            r_phase_ticks <= '0;
            r_echo_ticks  <= '0;
            r_hold_active <= 1'b0;
            r_hold_ticks  <= '0;
            r_first_echo  <= '0;
            r_block       <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_phase_ticks <= n_phase_ticks;
            r_echo_ticks  <= n_echo_ticks;
            r_hold_active <= n_hold_active;
            r_hold_ticks  <= n_hold_ticks;
            r_first_echo  <= n_first_echo;
            r_block       <= n_block;
        end
    end

    assign o_res = w_res;

`ifndef SYNTHESIS
    a_hold_ticks_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_hold_active |-> (r_hold_ticks == '0))
        else $error("hold timer running while hold is inactive");
    a_echo_ticks_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_HIGH) |-> (r_echo_ticks == '0))
        else $error("echo counter nonzero outside the echo high phase");
    a_high_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HIGH) |-> (r_echo_ticks != '0))
        else $error("echo high phase with empty echo counter");
`endif

endmodule

// ===== rtl/core/ultrasonic_obstacle_detector.sv =====
// ultrasonic ranging controller with obstacle hold logic. every input word is one
// microsecond tick of the echo pin plus a run enable, and every accepted word gives
// exactly one result word. the controller drives the trigger low for 2 ticks and high
// for 10, waits for the echo to rise, times the high pulse, then idles for gap_us
// ticks (at least one). echo_timeout_us bounds both the rise wait and the pulse
// length; a timeout reports measure_done with echo_valid low. a finished echo
// reports echo_us and distance_mm = floor(echo_us * 343 / 2000). an echo at or below
// near_limit_us starts a hold timer; once hold_time_us ticks have passed, a near echo
// no longer than the one that started the timer sets blocked with a block_event
// pulse. a far echo, a timeout or run low clears the timer and releases the block
// with an unblock_event pulse. rate: one word per clock while i_out_ready stays high,
// passing an input register, one pass of tick logic plus a 16 x 26 constant
// multiply for the distance, and a result register. a stalled result register
// holds the word in the input register and stops the next word from entering.
// settings sit on an apb port at byte addresses 0 (echo_timeout_us, reset 10000),
// 4 (near_limit_us, 1749), 8 (hold_time_us, 750000) and 12 (gap_us, 50000); write
// them only while the block is idle.
module ultrasonic_obstacle_detector (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_echo_level,
    input  logic                        i_run,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_trig_level,
    output logic                        o_measure_done,
    output logic                        o_echo_valid,
    output logic [uod_pkg::ECHO_W-1:0]  o_echo_us,
    output logic [uod_pkg::DIST_W-1:0]  o_distance_mm,
    output logic                        o_blocked,
    output logic                        o_block_event,
    output logic                        o_unblock_event,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [uod_pkg::APB_AW-1:0]  paddr,
    input  logic [uod_pkg::APB_DW-1:0]  pwdata,
    output logic [uod_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import uod_pkg::*;

    // input register
    logic              r_in_valid;
    logic              r_echo_level;
    logic              r_run;
    // result register
    logic              r_out_valid;
    t_result           r_res;
    logic [DIST_W-1:0] r_distance_mm;

    t_cfg              w_cfg;
    t_result           w_res;
    logic [DIST_W-1:0] w_distance_mm;
    logic              w_advance;

    // a word moves from the input register to the result register when the
    // result register is empty or being emptied this cycle
    assign w_advance  = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | w_advance;
    assign pready     = 1'b1;

    uod_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    // tick logic, state advances once per word
    uod_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_advance),
        .i_echo_level (r_echo_level),
        .i_run        (r_run),
        .i_cfg        (w_cfg),
        .o_res        (w_res)
    );

    // echo_us is zero unless an echo finished, so the distance is zero too
    uod_dist u_dist (
        .i_echo_us     (w_res.echo_us),
        .o_distance_mm (w_distance_mm)
    );

    // handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_echo_level <= i_echo_level;
            r_run        <= i_run;
        end
        if (w_advance) begin
            r_res         <= w_res;
            r_distance_mm <= w_distance_mm;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_trig_level    = r_res.trig_level;
    assign o_measure_done  = r_res.measure_done;
    assign o_echo_valid    = r_res.echo_valid;
    assign o_echo_us       = r_res.echo_us;
    assign o_distance_mm   = r_distance_mm;
    assign o_blocked       = r_res.blocked;
    assign o_block_event   = r_res.block_event;
    assign o_unblock_event = r_res.unblock_event;

`ifndef SYNTHESIS
    a_block_event_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_block_event) |-> (o_blocked && !o_unblock_event))
        else $error("block word without block state");
    a_unblock_event_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_unblock_event) |-> !o_blocked)
        else $error("unblock word with block still set");
    a_valid_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_echo_valid) |-> (o_measure_done && !o_trig_level))
        else $error("echo reported outside a finished measurement");
    a_timeout_no_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_echo_valid) |-> ((o_echo_us == '0) && (o_distance_mm == '0)))
        else $error("echo time reported without an echo");
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("word lost between input and result register");
`endif

endmodule
